// ===== design/kwm_pkg.sv =====
// Package for the keyword line matcher: sizes, codes, shared types and the
// byte classification functions. No dependencies.
package kwm_pkg;

   localparam int MAX_KEY    = 32;
   localparam int WIN_DEPTH  = MAX_KEY + 1;
   localparam int CHAR_W     = 8;
   localparam int KEY_IDX_W  = $clog2(MAX_KEY);
   localparam int KEY_LEN_W  = 6;
   localparam int SEEN_W     = $clog2(WIN_DEPTH + 1);
   localparam int SHIFT_W    = $clog2(MAX_KEY);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = KEY_LEN_W;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_LINE = 1'b1
   } kwm_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_LENGTH     = 2'd0,
      CSR_CASE_SENSITIVE = 2'd1,
      CSR_WHOLE_WORD     = 2'd2
   } kwm_csr_index_type;

   typedef struct packed {
      logic [KEY_LEN_W-1:0] key_length;
      logic                 case_sensitive;
      logic                 whole_word;
   } kwm_cfg_type;

   typedef struct packed {
      logic                 mode;
      logic [CHAR_W-1:0]    char_value;
      logic [KEY_IDX_W-1:0] key_index;
      logic                 end_of_line;
   } kwm_item_type;

   function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c,
                                                   input logic case_sensitive);
      if (!case_sensitive && c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'h20;
      end
      return c;
   endfunction

   function automatic logic word_byte(input logic [CHAR_W-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == 8'h5F);
   endfunction

endpackage

// ===== design/kwm_if.sv =====
// Valid/ready channel interfaces of the keyword line matcher: line and
// keyword transactions, match results and register writes. Uses kwm_pkg.
interface kwm_req_if import kwm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [CHAR_W-1:0]    char_value;
   logic [KEY_IDX_W-1:0] key_index;
   logic                 end_of_line;

   modport source (output valid, mode, char_value, key_index, end_of_line,
                   input ready);
   modport sink (input valid, mode, char_value, key_index, end_of_line,
                 output ready);
endinterface

interface kwm_rsp_if;
   logic valid;
   logic ready;
   logic line_has_match;

   modport source (output valid, line_has_match, input ready);
   modport sink (input valid, line_has_match, output ready);
endinterface

interface kwm_csr_if import kwm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink (input valid, reg_index, write_data, output ready);
endinterface

// ===== design/kwm_line_engine.sv =====
// Keyword store, text window and line state of the keyword line matcher,
// with the parallel window compare. Uses kwm_pkg.
module kwm_line_engine
   import kwm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  kwm_item_type item,
   input  kwm_cfg_type  cfg,
   output logic         line_result
);

   logic [CHAR_W-1:0]         key_ff [MAX_KEY];
   logic [CHAR_W-1:0]         recent_ff [WIN_DEPTH];
   logic [CHAR_W-1:0]         recent_in [WIN_DEPTH];
   logic [SEEN_W-1:0]         seen_ff, seen_in;
   logic                      hit_ff, hit_in;
   logic                      ended_ff, ended_in;

   logic [(WIN_DEPTH+1)*CHAR_W-1:0] v_vec;
   logic [(WIN_DEPTH+1)*CHAR_W-1:0] s_vec;
   logic [KEY_LEN_W-1:0]      shift_full;
   logic [SHIFT_W-1:0]        shift_amt;
   logic                      len_ok;
   logic [MAX_KEY-1:0]        eq_prev, eq_cur;
   logic [SEEN_W:0]           seen_plus;
   logic                      match_prev, match_cur;
   logic                      is_line;
   logic [CHAR_W-1:0]         b;

   assign b       = item.char_value;
   assign is_line = step && (item.mode == MODE_LINE);
   assign len_ok  = (cfg.key_length != '0) &&
                    (cfg.key_length <= KEY_LEN_W'(MAX_KEY));
   assign shift_full = KEY_LEN_W'(MAX_KEY) - cfg.key_length;
   assign shift_amt  = shift_full[SHIFT_W-1:0];
   assign seen_plus  = {1'b0, seen_ff} + (SEEN_W+1)'(1);

   // Window reversed so that the newest bytes sit at the top end.
   always_comb begin
      v_vec[(WIN_DEPTH+1)*CHAR_W-1 -: CHAR_W] = b;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         v_vec[(WIN_DEPTH-1-i)*CHAR_W +: CHAR_W] = recent_ff[i];
      end
   end

   assign s_vec = v_vec >> {shift_amt, 3'b000};

   always_comb begin
      for (int j = 0; j < MAX_KEY; j++) begin
         if (KEY_LEN_W'(j) >= cfg.key_length) begin
            eq_prev[j] = 1'b1;
            eq_cur[j]  = 1'b1;
         end else begin
            eq_prev[j] = (key_ff[j] != '0) &&
               (fold_byte(key_ff[j], cfg.case_sensitive) ==
                fold_byte(s_vec[(j+1)*CHAR_W +: CHAR_W], cfg.case_sensitive));
            eq_cur[j]  = (key_ff[j] != '0) &&
               (fold_byte(key_ff[j], cfg.case_sensitive) ==
                fold_byte(s_vec[(j+2)*CHAR_W +: CHAR_W], cfg.case_sensitive));
         end
      end
   end

   assign match_prev = len_ok && (&eq_prev) &&
                       ({1'b0, seen_ff} >= {1'b0, cfg.key_length}) &&
                       (!cfg.whole_word ||
                        (({1'b0, seen_ff} <= {1'b0, cfg.key_length}) ||
                         !word_byte(s_vec[0 +: CHAR_W])) && !word_byte(b));

   assign match_cur = len_ok && (&eq_cur) &&
                      (seen_plus >= (SEEN_W+1)'(cfg.key_length)) &&
                      (!cfg.whole_word ||
                       ({1'b0, seen_ff} < {1'b0, cfg.key_length}) ||
                       !word_byte(s_vec[CHAR_W +: CHAR_W]));

   always_comb begin
      recent_in = recent_ff;
      seen_in   = seen_ff;
      hit_in    = hit_ff;
      ended_in  = ended_ff;
      if (is_line && !ended_ff) begin
         if (match_prev) begin
            hit_in = 1'b1;
         end
         if (b == '0) begin
            ended_in = 1'b1;
         end else begin
            if (item.end_of_line && match_cur) begin
               hit_in = 1'b1;
            end
            recent_in[0] = b;
            for (int i = 1; i < WIN_DEPTH; i++) begin
               recent_in[i] = recent_ff[i-1];
            end
            if (seen_ff < SEEN_W'(WIN_DEPTH)) begin
               seen_in = seen_plus[SEEN_W-1:0];
            end
         end
      end
   end

   assign line_result = hit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         hit_ff   <= 1'b0;
         ended_ff <= 1'b0;
      end else if (is_line && item.end_of_line) begin
         seen_ff  <= '0;
         hit_ff   <= 1'b0;
         ended_ff <= 1'b0;
      end else begin
         seen_ff  <= seen_in;
         hit_ff   <= hit_in;
         ended_ff <= ended_in;
      end
   end

   // Window bytes beyond the fill count are never used, so they are not cleared.
   always_ff @(posedge clock) begin
      recent_ff <= recent_in;
   end

   always_ff @(posedge clock) begin
      if (step && (item.mode == MODE_LOAD)) begin
         key_ff[item.key_index] <= b;
      end
   end

   property p_ended_holds_seen;
      @(posedge clock) disable iff (reset)
         (ended_ff && !(is_line && item.end_of_line)) |=> $stable(seen_ff);
   endproperty
   a_ended_holds_seen: assert property (p_ended_holds_seen)
      else $error("Window advanced after the text had ended.");

   property p_seen_bound;
      @(posedge clock) disable iff (reset)
         seen_ff <= SEEN_W'(WIN_DEPTH);
   endproperty
   a_seen_bound: assert property (p_seen_bound)
      else $error("Fill count exceeded the window depth.");

endmodule

// ===== design/keyword_line_matcher_core.sv =====
// Results are registered: the input register takes a line-ending transaction when it
// is accepted, the result register its result when processed; a stall can come between.
// Throughput: one transaction per cycle, except while a line end waits for the previous
// result to be taken. Reset clears the configuration, the line state and both channel
// valid flags; the keyword store is undefined until written. Uses kwm_pkg and kwm_if.
module keyword_line_matcher_core
   import kwm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   kwm_req_if.sink  req_chan,
   kwm_rsp_if.source rsp_chan,
   kwm_csr_if.sink  csr_chan
);

   kwm_cfg_type  cfg_ff;
   kwm_item_type item_ff;
   logic         in_valid_ff;
   logic         rsp_valid_ff;
   logic         match_ff;
   logic         gives_result;
   logic         advance;
   logic         line_result;

   assign gives_result = (item_ff.mode == MODE_LINE) && item_ff.end_of_line;
   assign advance      = in_valid_ff &&
                         (!gives_result || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_KEY_LENGTH:     cfg_ff.key_length     <= csr_chan.write_data;
            CSR_CASE_SENSITIVE: cfg_ff.case_sensitive <= csr_chan.write_data[0];
            CSR_WHOLE_WORD:     cfg_ff.whole_word     <= csr_chan.write_data[0];
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff.mode        <= req_chan.mode;
         item_ff.char_value  <= req_chan.char_value;
         item_ff.key_index   <= req_chan.key_index;
         item_ff.end_of_line <= req_chan.end_of_line;
      end
   end

   kwm_line_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (item_ff),
      .cfg         (cfg_ff),
      .line_result (line_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && gives_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && gives_result) begin
         match_ff <= line_result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.line_has_match = match_ff;

   property p_no_overwrite;
      @(posedge clock) disable iff (reset)
         (req_chan.valid && req_chan.ready) |-> (!in_valid_ff || advance);
   endproperty
   a_no_overwrite: assert property (p_no_overwrite)
      else $error("Input register overwritten before its transaction was processed.");

   property p_result_issued;
      @(posedge clock) disable iff (reset)
         (advance && gives_result) |=> rsp_valid_ff;
   endproperty
   a_result_issued: assert property (p_result_issued)
      else $error("Line end processed without a result being issued.");

   property p_stalled_item_kept;
      @(posedge clock) disable iff (reset)
         (in_valid_ff && !advance) |=> (in_valid_ff && $stable(item_ff));
   endproperty
   a_stalled_item_kept: assert property (p_stalled_item_kept)
      else $error("Stalled transaction lost from the input register.");

endmodule
